FILE: hw/rtl/rmr_pkg.sv
package rmr_pkg;

  localparam int MAX_RECTS  = 16;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 768;

  localparam int RESET_WIDTH  = 352;
  localparam int RESET_HEIGHT = 288;

  localparam int CMD_W   = 2;
  localparam int COORD_W = 12;
  localparam int STS_W   = 2;
  localparam int PIX_X_W = 10;
  localparam int PIX_Y_W = 10;

  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 10;

  localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);
  localparam int EFF_H_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_PIXEL  = 2'd2
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NORM = 4'b0010,
    S_EVAL = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
  } in_word_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic               is_pixel;
    logic               mask_black;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic               frame_end;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } rect_t;

  typedef struct packed {
    logic [CFG_WIDTH_W-1:0]  frame_width;
    logic [CFG_HEIGHT_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic norm;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/rmr_in_if.sv
interface rmr_in_if;
  import rmr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] left_x;
  logic signed [COORD_W-1:0] top_y;
  logic signed [COORD_W-1:0] right_x;
  logic signed [COORD_W-1:0] bottom_y;

  modport source (
    output valid, command, left_x, top_y, right_x, bottom_y,
    input  ready
  );

  modport sink (
    input  valid, command, left_x, top_y, right_x, bottom_y,
    output ready
  );
endinterface

FILE: hw/rtl/rmr_out_if.sv
interface rmr_out_if;
  import rmr_pkg::*;

  logic               valid;
  logic               ready;
  logic [STS_W-1:0]   status;
  logic               is_pixel;
  logic               mask_black;
  logic [PIX_X_W-1:0] pixel_x;
  logic [PIX_Y_W-1:0] pixel_y;
  logic               frame_end;

  modport source (
    output valid, status, is_pixel, mask_black, pixel_x, pixel_y, frame_end,
    input  ready
  );

  modport sink (
    input  valid, status, is_pixel, mask_black, pixel_x, pixel_y, frame_end,
    output ready
  );
endinterface

FILE: hw/rtl/rmr_regs.sv
module rmr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmr_pkg::PADDR_W-1:0]    paddr,
  input  logic [rmr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rmr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output rmr_pkg::cfg_t                  cfg_o
);
  import rmr_pkg::*;

  logic [CFG_WIDTH_W-1:0]  width_q, width_d;
  logic [CFG_HEIGHT_W-1:0] height_q, height_d;
  logic [REG_IDX_W-1:0]    idx;
  logic                    wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    case (idx)
      REG_FRAME_WIDTH: begin
        prdata = APB_DATA_W'(width_q);
        if (wr_en) width_d = pwdata[CFG_WIDTH_W-1:0];
      end
      REG_FRAME_HEIGHT: begin
        prdata = APB_DATA_W'(height_q);
        if (wr_en) height_d = pwdata[CFG_HEIGHT_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_WIDTH_W'(RESET_WIDTH);
      height_q <= CFG_HEIGHT_W'(RESET_HEIGHT);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.frame_width  = width_q;
  assign cfg_o.frame_height = height_q;
endmodule

FILE: hw/rtl/rmr_ctrl.sv
module rmr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmr_pkg::ctrl_cmd_t cmd_o
);
  import rmr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

FILE: hw/rtl/rmr_dp.sv
module rmr_dp #(
  parameter int MaxRects = rmr_pkg::MAX_RECTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmr_pkg::ctrl_cmd_t  cmd_i,
  input  rmr_pkg::cfg_t       cfg_i,
  input  rmr_pkg::in_word_t   in_word_i,
  output rmr_pkg::out_word_t  out_word_o
);
  import rmr_pkg::*;

  localparam int CntW = $clog2(MaxRects + 1);
  localparam int IdxW = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int SW   = COORD_W + 1;

  in_word_t       in_q;
  rect_t          rect_q [MaxRects];
  logic [MaxRects-1:0] hit_q, hit_d;
  out_word_t      out_q, out_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [EFF_W_W-1:0] ew, ew_m1;
  logic [EFF_H_W-1:0] eh, eh_m1;
  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic               col_wrap;
  logic [ROW_W:0]     row_n;
  logic               table_full, rect_bad, do_store;

  logic signed [SW-1:0] col_s, row_s, wm1_s, hm1_s;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      ew = EFF_W_W'(1);
    end else if (EFF_W_W'(cfg_i.frame_width) > EFF_W_W'(MAX_WIDTH)) begin
      ew = EFF_W_W'(MAX_WIDTH);
    end else begin
      ew = EFF_W_W'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      eh = EFF_H_W'(1);
    end else if (EFF_H_W'(cfg_i.frame_height) > EFF_H_W'(MAX_HEIGHT)) begin
      eh = EFF_H_W'(MAX_HEIGHT);
    end else begin
      eh = EFF_H_W'(cfg_i.frame_height);
    end
  end

  assign ew_m1 = ew - EFF_W_W'(1);
  assign eh_m1 = eh - EFF_H_W'(1);

  assign col_s = $signed({{(SW-COL_W){1'b0}}, col_q});
  assign row_s = $signed({{(SW-ROW_W){1'b0}}, row_q});
  assign wm1_s = $signed({{(SW-EFF_W_W){1'b0}}, ew_m1});
  assign hm1_s = $signed({{(SW-EFF_H_W){1'b0}}, eh_m1});

  always_comb begin
    logic signed [SW-1:0] lo_x, lo_y, hi_x, hi_y, x0_e, y0_e, x1_e, y1_e;
    for (int i = 0; i < MaxRects; i++) begin
      x0_e = SW'(rect_q[i].x0);
      y0_e = SW'(rect_q[i].y0);
      x1_e = SW'(rect_q[i].x1);
      y1_e = SW'(rect_q[i].y1);
      lo_x = (x0_e > 0) ? x0_e : '0;
      lo_y = (y0_e > 0) ? y0_e : '0;
      hi_x = (x1_e < wm1_s) ? x1_e : wm1_s;
      hi_y = (y1_e < hm1_s) ? y1_e : hm1_s;
      hit_d[i] = (CntW'(i) < count_q) && (col_s >= lo_x) && (col_s < hi_x)
                 && (row_s >= lo_y) && (row_s < hi_y);
    end
  end

  assign col_wrap   = (EFF_W_W'(col_q) >= ew);
  assign row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
  assign row_n      = col_wrap ? row_inc : {1'b0, row_q};
  assign col_inc    = {1'b0, col_q} + (COL_W+1)'(1);
  assign table_full = (count_q >= CntW'(MaxRects));
  assign rect_bad   = (in_q.left_x > in_q.right_x) || (in_q.top_y > in_q.bottom_y);
  assign do_store   = cmd_i.commit && (in_q.command == CMD_APPEND)
                      && !table_full && !rect_bad;

  always_comb begin
    count_d = count_q;
    col_d   = col_q;
    row_d   = row_q;
    out_d   = '0;
    if (cmd_i.norm && (in_q.command == CMD_PIXEL)) begin
      if (col_wrap) col_d = '0;
      row_d = (row_n >= (ROW_W+1)'(eh)) ? '0 : row_n[ROW_W-1:0];
    end
    if (cmd_i.commit) begin
      case (in_q.command)
        CMD_CLEAR: begin
          count_d = '0;
          col_d   = '0;
          row_d   = '0;
        end
        CMD_APPEND: begin
          if (table_full) begin
            out_d.status = STS_FULL;
          end else if (rect_bad) begin
            out_d.status = STS_BAD;
          end else begin
            out_d.status = STS_OK;
            count_d      = count_q + CntW'(1);
          end
        end
        CMD_PIXEL: begin
          out_d.status     = STS_OK;
          out_d.is_pixel   = 1'b1;
          out_d.mask_black = |hit_q;
          out_d.pixel_x    = PIX_X_W'(col_q);
          out_d.pixel_y    = PIX_Y_W'(row_q);
          out_d.frame_end  = (EFF_W_W'(col_q) == ew_m1) && (EFF_H_W'(row_q) == eh_m1);
          if (col_inc >= (COL_W+1)'(ew)) begin
            col_d = '0;
            row_d = (row_inc >= (ROW_W+1)'(eh)) ? '0 : row_inc[ROW_W-1:0];
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
        default: out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      count_q <= count_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_word_i;
    if (cmd_i.eval) hit_q <= hit_d;
    if (cmd_i.commit) out_q <= out_d;
    if (do_store) begin
      rect_q[count_q[IdxW-1:0]] <= '{x0: in_q.left_x, y0: in_q.top_y,
                                     x1: in_q.right_x, y1: in_q.bottom_y};
    end
  end

  assign out_word_o = out_q;
endmodule

FILE: hw/rtl/rectangle_mask_rasterizer.sv
// A new word is accepted only in the idle state, after the previous word has
// been emitted; the four-state sequencer (capture, raster wrap, parallel
// rectangle compare, emit) waits in emit while the result slot is occupied.
// Reset: asynchronous, active low; empties the table, rewinds the raster and
// loads 352 x 288; rectangle entries hold no reset value and need no clearing.
module rectangle_mask_rasterizer #(
  parameter int MaxRects = rmr_pkg::MAX_RECTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rmr_in_if.sink                         in_chan,
  rmr_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmr_pkg::PADDR_W-1:0]    paddr,
  input  logic [rmr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rmr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rmr_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  rmr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_chan.ready),
    .cmd_o       (cmd)
  );

  assign in_word.command  = in_chan.command;
  assign in_word.left_x   = in_chan.left_x;
  assign in_word.top_y    = in_chan.top_y;
  assign in_word.right_x  = in_chan.right_x;
  assign in_word.bottom_y = in_chan.bottom_y;

  rmr_dp #(
    .MaxRects (MaxRects)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_word_i  (in_word),
    .out_word_o (out_word)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.status     = out_word.status;
  assign out_chan.is_pixel   = out_word.is_pixel;
  assign out_chan.mask_black = out_word.mask_black;
  assign out_chan.pixel_x    = out_word.pixel_x;
  assign out_chan.pixel_y    = out_word.pixel_y;
  assign out_chan.frame_end  = out_word.frame_end;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while a word is in flight");

  a_frame_end_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && out_chan.frame_end) |-> out_chan.is_pixel)
    else $error("frame end on a non-pixel word");

  a_non_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && !out_chan.is_pixel) |->
      (!out_chan.mask_black && out_chan.pixel_x == '0 && out_chan.pixel_y == '0))
    else $error("non-pixel word carries pixel data");

  a_pixel_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && out_chan.is_pixel) |-> (out_chan.status == STS_OK))
    else $error("pixel word with refusal status");
`endif
endmodule

FILE: verif/rmr_mask_checker.sv
module rmr_mask_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rmr_in_if                              in_mon,
  rmr_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmr_pkg::PADDR_W-1:0]    paddr,
  input  logic [rmr_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending,
  output int                             pixel_count,
  output int                             black_count,
  output int                             frame_end_count,
  output int                             refused_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmr_pkg::*;

  int        rect_box [MAX_RECTS][4];
  int        rect_cnt;
  int        raster_x;
  int        raster_y;
  int        width_reg  = RESET_WIDTH;
  int        height_reg = RESET_HEIGHT;
  out_word_t mask_q [$];
  out_word_t want_word;
  in_word_t  seen_word;

  function automatic logic hits_rect(input int x, input int y, input int fw, input int fh);
    int lo_x, lo_y, hi_x, hi_y;
    for (int i = 0; i < rect_cnt; i++) begin
      lo_x = (rect_box[i][0] > 0) ? rect_box[i][0] : 0;
      lo_y = (rect_box[i][1] > 0) ? rect_box[i][1] : 0;
      hi_x = (rect_box[i][2] < fw - 1) ? rect_box[i][2] : fw - 1;
      hi_y = (rect_box[i][3] < fh - 1) ? rect_box[i][3] : fh - 1;
      if (x >= lo_x && x < hi_x && y >= lo_y && y < hi_y) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_mask(input in_word_t w);
    out_word_t r;
    int        x0, y0, x1, y1, fw, fh;
    r  = '0;
    x0 = $signed(w.left_x);
    y0 = $signed(w.top_y);
    x1 = $signed(w.right_x);
    y1 = $signed(w.bottom_y);
    fw = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    fh = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    case (w.command)
      CMD_CLEAR: begin
        rect_cnt = 0;
        raster_x = 0;
        raster_y = 0;
      end
      CMD_APPEND: begin
        if (rect_cnt >= MAX_RECTS) begin
          r.status = STS_FULL;
        end else if (x0 > x1 || y0 > y1) begin
          r.status = STS_BAD;
        end else begin
          rect_box[rect_cnt] = '{x0, y0, x1, y1};
          rect_cnt++;
        end
      end
      CMD_PIXEL: begin
        // wrap a position left outside the frame by a size change
        if (raster_x >= fw) begin
          raster_x = 0;
          raster_y++;
        end
        if (raster_y >= fh) raster_y = 0;
        r.is_pixel   = 1'b1;
        r.mask_black = hits_rect(raster_x, raster_y, fw, fh);
        r.pixel_x    = PIX_X_W'(raster_x);
        r.pixel_y    = PIX_Y_W'(raster_y);
        r.frame_end  = (raster_x == fw - 1 && raster_y == fh - 1);
        raster_x++;
        if (raster_x >= fw) begin
          raster_x = 0;
          raster_y++;
          if (raster_y >= fh) raster_y = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_cnt   = 0;
      raster_x   = 0;
      raster_y   = 0;
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mask_q.delete();
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_FRAME_WIDTH) width_reg = int'(pwdata[CFG_WIDTH_W-1:0]);
        else if (paddr[PADDR_W-1:2] == REG_FRAME_HEIGHT)
          height_reg = int'(pwdata[CFG_HEIGHT_W-1:0]);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (mask_q.size() == 0) begin
          $error("result word with no input word outstanding");
          fail_count++;
        end else begin
          want_word = mask_q.pop_front();
          check_field("status", 16'(want_word.status), 16'(out_mon.status));
          check_field("is_pixel", 16'(want_word.is_pixel), 16'(out_mon.is_pixel));
          check_field("mask_black", 16'(want_word.mask_black), 16'(out_mon.mask_black));
          check_field("pixel_x", 16'(want_word.pixel_x), 16'(out_mon.pixel_x));
          check_field("pixel_y", 16'(want_word.pixel_y), 16'(out_mon.pixel_y));
          check_field("frame_end", 16'(want_word.frame_end), 16'(out_mon.frame_end));
          pixel_count     += want_word.is_pixel;
          black_count     += want_word.mask_black;
          frame_end_count += want_word.frame_end;
          refused_count   += (want_word.status != STS_OK);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        seen_word.command  = in_mon.command;
        seen_word.left_x   = in_mon.left_x;
        seen_word.top_y    = in_mon.top_y;
        seen_word.right_x  = in_mon.right_x;
        seen_word.bottom_y = in_mon.bottom_y;
        mask_q.push_back(predict_mask(seen_word));
      end
      pending = mask_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_PHASES = 10;
  localparam int PHASE_W [N_PHASES] = '{0, 1, 2047, 7, 1024, 3, 16, 1, 13, 5};
  localparam int PHASE_H [N_PHASES] = '{0, 1, 1023, 5, 768, 9, 2, 12, 1, 5};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count, pending, pixel_count, black_count, frame_end_count, refused_count;
  int words_sent;
  int words_taken;
  bit send_calm;
  bit recv_calm;

  rmr_in_if  in_chan ();
  rmr_out_if out_chan ();

  rectangle_mask_rasterizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rmr_mask_checker mask_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixel_count    (pixel_count),
    .black_count    (black_count),
    .frame_end_count(frame_end_count),
    .refused_count  (refused_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic cfg_write(input reg_idx_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input int x0, input int y0,
                           input int x1, input int y1);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid    <= 1'b1;
    in_chan.command  <= cmd;
    in_chan.left_x   <= COORD_W'(x0);
    in_chan.top_y    <= COORD_W'(y0);
    in_chan.right_x  <= COORD_W'(x1);
    in_chan.bottom_y <= COORD_W'(y1);
    do @(posedge clk_i); while (in_chan.ready !== 1'b1);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_words, input int fw, input int fh);
    int pick, x0, y0, x1, y1, t;
    repeat (n_words) begin
      pick = $urandom_range(0, 99);
      x0   = int'($urandom_range(0, fw + 4)) - 3;
      y0   = int'($urandom_range(0, fh + 4)) - 3;
      x1   = x0 + int'($urandom_range(0, fw / 2 + 2));
      y1   = y0 + int'($urandom_range(0, fh / 2 + 2));
      if ($urandom_range(0, 9) == 0) begin
        t  = x0;
        x0 = x1;
        x1 = t;
      end
      if ($urandom_range(0, 9) == 0) begin
        t  = y0;
        y0 = y1;
        y1 = t;
      end
      if ($urandom_range(0, 4) == 0) begin
        x0 = int'($urandom_range(0, 4095)) - 2048;
        y0 = int'($urandom_range(0, 4095)) - 2048;
        x1 = int'($urandom_range(0, 4095)) - 2048;
        y1 = int'($urandom_range(0, 4095)) - 2048;
      end
      if (pick < 3) send_word(CMD_CLEAR, x0, y0, x1, y1);
      else if (pick < 20) send_word(CMD_APPEND, x0, y0, x1, y1);
      else if (pick < 96) send_word(CMD_PIXEL, x0, y0, x1, y1);
      else send_word(CMD_UNUSED, x0, y0, x1, y1);
    end
  endtask

  // result side: random stalls, two long hold-offs
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (words_taken == 400 || words_taken == 1000) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      stall = recv_calm ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk_i); while (out_chan.valid !== 1'b1);
      words_taken++;
    end
  end

  initial begin
    int fw, fh;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_chan.valid    <= 1'b0;
    in_chan.command  <= CMD_CLEAR;
    in_chan.left_x   <= '0;
    in_chan.top_y    <= '0;
    in_chan.right_x  <= '0;
    in_chan.bottom_y <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame size, then a 3 x 2 frame with a rectangle spanning all coordinates
    send_word(CMD_PIXEL, 0, 0, 0, 0);
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 3);
    cfg_write(REG_FRAME_HEIGHT, 2);
    send_word(CMD_APPEND, -2048, -2048, 2047, 2047);
    repeat (6) send_word(CMD_PIXEL, 0, 0, 0, 0);
    send_word(CMD_APPEND, 5, 0, 4, 3);
    send_word(CMD_APPEND, 0, 3, 5, 2);
    send_word(CMD_UNUSED, -1, 2047, -2048, -1);
    send_word(CMD_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < MAX_RECTS; i++) send_word(CMD_APPEND, i * 127, -i, 2047, 2047 - i);
    send_word(CMD_APPEND, 9, 9, 1, 1);
    send_word(CMD_PIXEL, 0, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      fw = (PHASE_W[p] < 1) ? 1 : (PHASE_W[p] > MAX_WIDTH) ? MAX_WIDTH : PHASE_W[p];
      fh = (PHASE_H[p] < 1) ? 1 : (PHASE_H[p] > MAX_HEIGHT) ? MAX_HEIGHT : PHASE_H[p];
      cfg_write(REG_FRAME_WIDTH, PHASE_W[p]);
      cfg_write(REG_FRAME_HEIGHT, PHASE_H[p]);
      // keep the old raster position in some phases
      if (p % 3 != 2) send_word(CMD_CLEAR, 0, 0, 0, 0);
      run_phase(130, fw, fh);
      wait_idle();
    end

    $display("covered %0d words over %0d frame sizes: %0d pixels, %0d black, %0d frame ends",
             words_sent, N_PHASES + 2, pixel_count, black_count, frame_end_count);
    $display("%0d appends refused, receiver held off twice", refused_count);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rmr_pkg.sv
hw/rtl/rmr_in_if.sv
hw/rtl/rmr_out_if.sv
hw/rtl/rmr_regs.sv
hw/rtl/rmr_ctrl.sv
hw/rtl/rmr_dp.sv
hw/rtl/rectangle_mask_rasterizer.sv
verif/rmr_mask_checker.sv
verif/tb.sv
